// File: hw/rtl/bls_pkg.sv
// bls_pkg: shared types and constants for the line stepper.
// No dependencies.
package bls_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_W        = 24;
  localparam int ORIGIN_W       = 10;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = ORIGIN_W'(100);
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = ORIGIN_W'(200);
  localparam logic [COLOR_W-1:0]  COLOR_WHITE  = 24'hffffff;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } bls_action_t;

  typedef enum logic {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } bls_reg_t;

  // line control flags kept between pixels
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic y_major;
    logic drawing;
  } bls_flags_t;

endpackage

// File: hw/rtl/bls_step.sv
// bls_step: single-pass next-state and pixel logic of the line stepper.
// Depends on bls_pkg.
module bls_step import bls_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                act_start,
  input  logic [CB-1:0]       sx,
  input  logic [CB-1:0]       sy,
  input  logic [CB-1:0]       ex,
  input  logic [CB-1:0]       ey,
  input  logic [COLOR_W-1:0]  color_in,
  input  logic [ORIGIN_W-1:0] origin_x,
  input  logic [ORIGIN_W-1:0] origin_y,
  input  logic [CB-1:0]       cur_x,
  input  logic [CB-1:0]       cur_y,
  input  logic [CB-1:0]       major_end,
  input  logic [CB-1:0]       abs_dx,
  input  logic [CB-1:0]       abs_dy,
  input  logic [CB:0]         error_acc,
  input  logic [COLOR_W-1:0]  line_color,
  input  bls_flags_t          flags,
  output logic [CB-1:0]       cur_x_next,
  output logic [CB-1:0]       cur_y_next,
  output logic [CB-1:0]       major_end_next,
  output logic [CB-1:0]       abs_dx_next,
  output logic [CB-1:0]       abs_dy_next,
  output logic [CB:0]         error_acc_next,
  output logic [COLOR_W-1:0]  line_color_next,
  output bls_flags_t          flags_next,
  output logic                emit,
  output logic [CB:0]         pix_x,
  output logic [CB:0]         pix_y,
  output logic                pix_last
);

  localparam int SW = ((CB + 1) > (ORIGIN_W + 1)) ? (CB + 1) : (ORIGIN_W + 1);

  // start path
  logic [CB:0]   dx, dy, dx_mag, dy_mag;
  logic [CB-1:0] s_adx, s_ady;
  logic          s_ymaj, s_last;

  // step path
  logic [CB-1:0] major, minor, x_adv, y_adv, step_x, step_y;
  logic [CB+1:0] err_sum, err_diff;
  logic [CB:0]   err_step;
  logic          minor_step, step_last;

  logic [SW-1:0] px_sum, py_sum;

  assign dx     = {ex[CB-1], ex} - {sx[CB-1], sx};
  assign dy     = {ey[CB-1], ey} - {sy[CB-1], sy};
  assign dx_mag = dx[CB] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[CB] ? (~dy + 1'b1) : dy;
  assign s_adx  = dx_mag[CB-1:0];
  assign s_ady  = dy_mag[CB-1:0];
  assign s_ymaj = s_ady > s_adx;
  assign s_last = s_ymaj ? (sy == ey) : (sx == ex);

  assign major      = flags.y_major ? abs_dy : abs_dx;
  assign minor      = flags.y_major ? abs_dx : abs_dy;
  assign err_sum    = {1'b0, error_acc} + {2'b00, minor};
  assign err_diff   = err_sum - {2'b00, major};
  assign minor_step = err_sum >= {2'b00, major};
  assign err_step   = minor_step ? err_diff[CB:0] : err_sum[CB:0];
  assign x_adv      = flags.x_neg ? (cur_x - 1'b1) : (cur_x + 1'b1);
  assign y_adv      = flags.y_neg ? (cur_y - 1'b1) : (cur_y + 1'b1);
  assign step_x     = (!flags.y_major || minor_step) ? x_adv : cur_x;
  assign step_y     = (flags.y_major || minor_step) ? y_adv : cur_y;
  assign step_last  = flags.y_major ? (step_y == major_end) : (step_x == major_end);

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    major_end_next  = major_end;
    abs_dx_next     = abs_dx;
    abs_dy_next     = abs_dy;
    error_acc_next  = error_acc;
    line_color_next = line_color;
    flags_next      = flags;
    emit            = 1'b0;
    pix_last        = 1'b0;
    if (act_start) begin
      cur_x_next         = sx;
      cur_y_next         = sy;
      abs_dx_next        = s_adx;
      abs_dy_next        = s_ady;
      error_acc_next     = '0;
      major_end_next     = s_ymaj ? ey : ex;
      line_color_next    = (color_in == '0) ? COLOR_WHITE : color_in;
      flags_next.x_neg   = dx[CB];
      flags_next.y_neg   = dy[CB];
      flags_next.y_major = s_ymaj;
      flags_next.drawing = !s_last;
      emit               = 1'b1;
      pix_last           = s_last;
    end else if (flags.drawing) begin
      cur_x_next         = step_x;
      cur_y_next         = step_y;
      error_acc_next     = err_step;
      flags_next.drawing = !step_last;
      emit               = 1'b1;
      pix_last           = step_last;
    end
  end

  // screen offset; wraps to the pixel width
  assign px_sum = {{(SW-CB){cur_x_next[CB-1]}}, cur_x_next} + {{(SW-ORIGIN_W){1'b0}}, origin_x};
  assign py_sum = {{(SW-CB){cur_y_next[CB-1]}}, cur_y_next} + {{(SW-ORIGIN_W){1'b0}}, origin_y};
  assign pix_x  = px_sum[CB:0];
  assign pix_y  = py_sum[CB:0];

endmodule

// File: hw/rtl/bls_rbuf.sv
// bls_rbuf: two-entry result buffer between the step logic and the output.
// Depends on bls_pkg.
module bls_rbuf import bls_pkg::*; #(
  parameter int W = 2 * (COORD_BITS_DEF + 1) + COLOR_W + 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         dout_valid,
  input  logic         dout_ready,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/bresenham_line_stepper.sv
// bresenham_line_stepper: an accepted request passes through the input register,
// then the step logic into the result buffer, which drives the result channel.
// Throughput: one request per cycle while the result buffer has a free slot; the
// limit is the line state update (error add, compare, coordinate step) each request depends on.
// Synchronous active-high reset: idle, line state zero, origin_x=100, origin_y=200.
module bresenham_line_stepper import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic        [COLOR_W-1:0]    pixel_color,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   pixel_x,
  output logic signed [COORD_BITS:0]   pixel_y,
  output logic        [COLOR_W-1:0]    out_color,
  output logic                         last,
  // configuration (APB-style)
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int CB = COORD_BITS;
  localparam int RW = 2 * (CB + 1) + COLOR_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers: origin offsets, word addressed by paddr[2].
  // ---------------------------------------------------------------------------
  logic [ORIGIN_W-1:0] origin_x, origin_y;
  logic                cfg_wr;
  bls_reg_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = bls_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ORIGIN_X_RST;
      origin_y <= ORIGIN_Y_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ORIGIN_X: origin_x <= pwdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y: origin_y <= pwdata[ORIGIN_W-1:0];
        default:      origin_x <= origin_x;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_ORIGIN_X: prdata = {{(APB_DATA_W-ORIGIN_W){1'b0}}, origin_x};
      REG_ORIGIN_Y: prdata = {{(APB_DATA_W-ORIGIN_W){1'b0}}, origin_y};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. A held request advances into the step logic whenever the
  // result buffer has a free slot; ready depends on registers only.
  // ---------------------------------------------------------------------------
  logic                inq_valid;
  bls_action_t         inq_action;
  logic [CB-1:0]       inq_sx, inq_sy, inq_ex, inq_ey;
  logic [COLOR_W-1:0]  inq_color;
  logic                rb_full, adv;

  assign adv      = inq_valid && !rb_full;
  assign in_ready = !inq_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_action <= bls_action_t'(action);
      inq_sx     <= start_x;
      inq_sy     <= start_y;
      inq_ex     <= end_x;
      inq_ey     <= end_y;
      inq_color  <= pixel_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Line state, updated once per advanced request.
  // ---------------------------------------------------------------------------
  logic [CB-1:0]      cur_x, cur_y, major_end, abs_dx, abs_dy;
  logic [CB:0]        error_acc;
  logic [COLOR_W-1:0] line_color;
  bls_flags_t         flags;

  logic [CB-1:0]      cur_x_next, cur_y_next, major_end_next, abs_dx_next, abs_dy_next;
  logic [CB:0]        error_acc_next;
  logic [COLOR_W-1:0] line_color_next;
  bls_flags_t         flags_next;
  logic               emit, pix_last;
  logic [CB:0]        pix_x, pix_y;

  bls_step #(
    .CB (CB)
  ) u_step (
    .act_start       (inq_action == ACT_START),
    .sx              (inq_sx),
    .sy              (inq_sy),
    .ex              (inq_ex),
    .ey              (inq_ey),
    .color_in        (inq_color),
    .origin_x        (origin_x),
    .origin_y        (origin_y),
    .cur_x           (cur_x),
    .cur_y           (cur_y),
    .major_end       (major_end),
    .abs_dx          (abs_dx),
    .abs_dy          (abs_dy),
    .error_acc       (error_acc),
    .line_color      (line_color),
    .flags           (flags),
    .cur_x_next      (cur_x_next),
    .cur_y_next      (cur_y_next),
    .major_end_next  (major_end_next),
    .abs_dx_next     (abs_dx_next),
    .abs_dy_next     (abs_dy_next),
    .error_acc_next  (error_acc_next),
    .line_color_next (line_color_next),
    .flags_next      (flags_next),
    .emit            (emit),
    .pix_x           (pix_x),
    .pix_y           (pix_y),
    .pix_last        (pix_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      major_end  <= '0;
      abs_dx     <= '0;
      abs_dy     <= '0;
      error_acc  <= '0;
      line_color <= '0;
      flags      <= '0;
    end else if (adv) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      major_end  <= major_end_next;
      abs_dx     <= abs_dx_next;
      abs_dy     <= abs_dy_next;
      error_acc  <= error_acc_next;
      line_color <= line_color_next;
      flags      <= flags_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: a step while idle advances but pushes nothing.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] rb_din, rb_dout;

  assign rb_din = {pix_x, pix_y, line_color_next, pix_last};

  bls_rbuf #(
    .W (RW)
  ) u_rbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (adv && emit),
    .din        (rb_din),
    .full       (rb_full),
    .dout_valid (out_valid),
    .dout_ready (out_ready),
    .dout       (rb_dout)
  );

  assign pixel_x   = rb_dout[RW-1 -: (CB+1)];
  assign pixel_y   = rb_dout[RW-CB-2 -: (CB+1)];
  assign out_color = rb_dout[COLOR_W:1];
  assign last      = rb_dout[0];

endmodule
